>>> hw/rtl/ksa_pkg.sv
// ksa_pkg: shared types, codes and constants for the keyed sample statistics aggregator
// no dependencies; every other file but ksa_if.sv refers to it by scoped names

package ksa_pkg;

  localparam int MAX_ENTRIES_DEF  = 1024;
  localparam int HASH_BUCKETS_DEF = 1024;
  localparam int BIN_BYTES_DEF    = 16;
  localparam int SYM_BYTES_DEF    = 52;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // literal names, first character in the low byte, zero padded
  localparam logic [63:0] LIT_TOTAL  = 64'h00296C61746F7428;
  localparam logic [63:0] LIT_IDLE   = 64'h000029656C646928;
  localparam logic [63:0] LIT_SYSTEM = 64'h296D657473797328;
  localparam logic [63:0] LIT_USER   = 64'h0000297265737528;

  typedef enum logic [1:0] {
    PH_BINARY,
    PH_SYMBOL,
    PH_COUNT,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    STS_TALLIED,
    STS_BAD_BINARY,
    STS_BAD_SYMBOL,
    STS_BAD_COUNT,
    STS_FULL,
    STS_READ
  } status_t;

  typedef enum logic [2:0] {
    CLS_TOTAL,
    CLS_IDLE,
    CLS_SYSTEM,
    CLS_USER,
    CLS_PROC_TOTAL,
    CLS_SYMBOL
  } class_t;

  typedef enum logic [3:0] {
    TS_CLEAR,
    TS_IDLE,
    TS_MOD,
    TS_REM,
    TS_HEAD,
    TS_HLINK,
    TS_CMP,
    TS_NEW,
    TS_MUL,
    TS_TALLY,
    TS_RRSP
  } tbl_state_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [63:0] sq;
    logic [31:0] mn;
    logic [31:0] mx;
  } side_stats_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] count;
    logic [31:0] hash;
  } line_info_t;

  localparam side_stats_t STATS_FRESH = '{sum: 32'd0, sq: 64'd0, mn: '1, mx: 32'd0};

endpackage

>>> hw/rtl/ksa_if.sv
// ksa_in_if and ksa_out_if: valid/ready channels for record bytes and results
// depends on nothing

interface ksa_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       side;
  logic [9:0] entry_index;
  modport source(output valid, req_type, data_byte, side, entry_index, input ready);
  modport sink(input valid, req_type, data_byte, side, entry_index, output ready);
endinterface

interface ksa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  entry_number;
  logic        is_new;
  logic [2:0]  entry_class;
  logic        entry_valid;
  logic [31:0] total_sum;
  logic [63:0] square_sum;
  logic [31:0] least_count;
  logic [31:0] greatest_count;
  modport source(output valid, status, entry_number, is_new, entry_class, entry_valid,
                 total_sum, square_sum, least_count, greatest_count, input ready);
  modport sink(input valid, status, entry_number, is_new, entry_class, entry_valid,
               total_sum, square_sum, least_count, greatest_count, output ready);
endinterface

>>> hw/rtl/keyed_sample_stats_aggregator.sv
// keyed_sample_stats_aggregator: one item at a time; a text byte gives no result.
// error line end: result in the cycle after its transfer; read: entry read, then result via TS_RRSP.
// tallying line end: result after bucket by reciprocal multiply, head read, chain walk over the
// bucket entries, entry creation when none matches, square and update; full table: result after
// the head read and chain walk. input stalls meanwhile and while a result waits.
// after reset the bucket heads are cleared, one per cycle.

module keyed_sample_stats_aggregator #(
  parameter int MAX_ENTRIES  = ksa_pkg::MAX_ENTRIES_DEF,
  parameter int HASH_BUCKETS = ksa_pkg::HASH_BUCKETS_DEF,
  parameter int BIN_BYTES    = ksa_pkg::BIN_BYTES_DEF,
  parameter int SYM_BYTES    = ksa_pkg::SYM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ksa_in_if.sink    in_ch,
  ksa_out_if.source out_ch
);

  ksa_pkg::line_info_t    info;
  logic [BIN_BYTES*8-1:0] bin_buf;
  logic [SYM_BYTES*8-1:0] sym_buf;
  logic                   byte_we;
  logic                   line_clr;

  ksa_parser #(
    .BIN_BYTES(BIN_BYTES),
    .SYM_BYTES(SYM_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_we (byte_we),
    .byte_in (in_ch.data_byte),
    .line_clr(line_clr),
    .info    (info),
    .bin_buf (bin_buf),
    .sym_buf (sym_buf)
  );

  ksa_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .HASH_BUCKETS(HASH_BUCKETS),
    .BIN_BYTES   (BIN_BYTES),
    .SYM_BYTES   (SYM_BYTES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .info    (info),
    .bin_buf (bin_buf),
    .sym_buf (sym_buf),
    .byte_we (byte_we),
    .line_clr(line_clr)
  );

endmodule

>>> hw/rtl/ksa_parser.sv
// ksa_parser: splits record text into name buffers and count, hashing names as they arrive
// depends on ksa_pkg

module ksa_parser #(
  parameter int BIN_BYTES = ksa_pkg::BIN_BYTES_DEF,
  parameter int SYM_BYTES = ksa_pkg::SYM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_we,
  input  logic [7:0]             byte_in,
  input  logic                   line_clr,
  output ksa_pkg::line_info_t    info,
  output logic [BIN_BYTES*8-1:0] bin_buf,
  output logic [SYM_BYTES*8-1:0] sym_buf
);

  localparam int MAXB = (BIN_BYTES > SYM_BYTES) ? BIN_BYTES : SYM_BYTES;
  localparam int POSW = $clog2(MAXB + 1);

  ksa_pkg::phase_t        phase_r, phase_nxt;
  logic [POSW-1:0]        pos_r, pos_nxt;
  logic                   ended_r, ended_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [31:0]            hb_r, hb_nxt, hs_r, hs_nxt;
  logic [BIN_BYTES*8-1:0] bin_r, bin_nxt;
  logic [SYM_BYTES*8-1:0] sym_r, sym_nxt;
  logic                   is_tab, is_digit;
  logic [7:0]             digit;
  logic [31:0]            hash_cur, hash_step;

  assign is_tab    = (byte_in == ksa_pkg::CH_TAB);
  assign is_digit  = (byte_in >= ksa_pkg::CH_ZERO) && (byte_in <= ksa_pkg::CH_NINE);
  assign digit     = byte_in - ksa_pkg::CH_ZERO;
  assign hash_cur  = (phase_r == ksa_pkg::PH_BINARY) ? hb_r : hs_r;
  // h * 31 + byte
  assign hash_step = (hash_cur << 5) - hash_cur + {24'd0, byte_in};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ended_nxt = ended_r;
    acc_nxt   = acc_r;
    hb_nxt    = hb_r;
    hs_nxt    = hs_r;
    bin_nxt   = bin_r;
    sym_nxt   = sym_r;
    if (line_clr) begin
      phase_nxt = ksa_pkg::PH_BINARY;
      pos_nxt   = '0;
      ended_nxt = 1'b0;
      acc_nxt   = '0;
      hb_nxt    = '0;
      hs_nxt    = '0;
      bin_nxt   = '0;
      sym_nxt   = '0;
    end else if (byte_we) begin
      case (phase_r)
        ksa_pkg::PH_BINARY: begin
          if (is_tab) begin
            phase_nxt = ksa_pkg::PH_SYMBOL;
            pos_nxt   = '0;
            ended_nxt = 1'b0;
          end else if (pos_r < POSW'(BIN_BYTES)) begin
            for (int i = 0; i < BIN_BYTES; i++) begin
              if (pos_r == POSW'(i) && !ended_r) bin_nxt[i*8 +: 8] = byte_in;
            end
            pos_nxt = pos_r + 1'b1;
            if (!ended_r && byte_in != 8'd0) hb_nxt = hash_step;
            if (byte_in == 8'd0) ended_nxt = 1'b1;
          end
        end
        ksa_pkg::PH_SYMBOL: begin
          if (is_tab) begin
            phase_nxt = ksa_pkg::PH_COUNT;
          end else if (pos_r < POSW'(SYM_BYTES)) begin
            for (int i = 0; i < SYM_BYTES; i++) begin
              if (pos_r == POSW'(i) && !ended_r) sym_nxt[i*8 +: 8] = byte_in;
            end
            pos_nxt = pos_r + 1'b1;
            if (!ended_r && byte_in != 8'd0) hs_nxt = hash_step;
            if (byte_in == 8'd0) ended_nxt = 1'b1;
          end
        end
        ksa_pkg::PH_COUNT: begin
          if (is_digit) acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, digit};
          else          phase_nxt = ksa_pkg::PH_SKIP;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ksa_pkg::PH_BINARY;
      pos_r   <= '0;
      ended_r <= 1'b0;
      acc_r   <= '0;
      hb_r    <= '0;
      hs_r    <= '0;
      bin_r   <= '0;
      sym_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
      acc_r   <= acc_nxt;
      hb_r    <= hb_nxt;
      hs_r    <= hs_nxt;
      bin_r   <= bin_nxt;
      sym_r   <= sym_nxt;
    end
  end

  assign info.phase = phase_r;
  assign info.count = acc_r;
  assign info.hash  = hb_r + hs_r;
  assign bin_buf    = bin_r;
  assign sym_buf    = sym_r;

endmodule

>>> hw/rtl/ksa_table.sv
// ksa_table: bucket head and entry memories with the lookup, insert and tally sequencer
// depends on ksa_pkg, ksa_in_if, ksa_out_if

module ksa_table #(
  parameter int MAX_ENTRIES  = ksa_pkg::MAX_ENTRIES_DEF,
  parameter int HASH_BUCKETS = ksa_pkg::HASH_BUCKETS_DEF,
  parameter int BIN_BYTES    = ksa_pkg::BIN_BYTES_DEF,
  parameter int SYM_BYTES    = ksa_pkg::SYM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ksa_in_if.sink                 in_ch,
  ksa_out_if.source              out_ch,
  input  ksa_pkg::line_info_t    info,
  input  logic [BIN_BYTES*8-1:0] bin_buf,
  input  logic [SYM_BYTES*8-1:0] sym_buf,
  output logic                   byte_we,
  output logic                   line_clr
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int BKW  = $clog2(HASH_BUCKETS);
  localparam int KEYW = (BIN_BYTES + SYM_BYTES) * 8;
  localparam logic [BKW-1:0] LAST_BKT = BKW'(HASH_BUCKETS - 1);
  // reciprocal of the bucket count, exact quotient for any 32-bit hash
  localparam int          QSH     = 32 + BKW;
  localparam logic [63:0] RECIP_W = ((64'd1 << QSH) + 64'(HASH_BUCKETS) - 64'd1) /
                                    64'(HASH_BUCKETS);
  localparam logic [32:0] RECIP   = RECIP_W[32:0];

  typedef struct packed {
    logic [KEYW-1:0]              key;
    logic [2:0]                   cls;
    logic [AW:0]                  nxt;
    ksa_pkg::side_stats_t [1:0]   st;
  } row_t;

  // memories
  logic [AW:0] head_mem [HASH_BUCKETS];
  row_t        ent_mem  [MAX_ENTRIES];
  logic [AW:0] head_rd_r;
  row_t        row_rd_r;
  logic        hwe, ewe;
  logic [BKW-1:0] hwa, hra;
  logic [AW:0]    hwd;
  logic [AW-1:0]  era;
  row_t           row_w;

  ksa_pkg::tbl_state_t state_r, state_nxt;
  logic [BKW-1:0]  clr_r, clr_nxt;
  logic [AW:0]     used_r, used_nxt;
  logic [31:0]     mod_r, mod_nxt;
  logic [31:0]     quo_r, quo_nxt;
  logic [BKW-1:0]  rem_r, rem_nxt;
  logic [AW-1:0]   e_r, e_nxt;
  logic [AW:0]     head_r, head_nxt;
  logic            side_r, side_nxt;
  logic [31:0]     n_r, n_nxt;
  logic [63:0]     sq_r, sq_nxt;
  row_t            row_r, row_nxt;
  logic            fresh_r, fresh_nxt;
  logic [9:0]      idx_r, idx_nxt;
  logic            idx_ok_r, idx_ok_nxt;

  logic                 ov_r, ov_nxt;
  ksa_pkg::status_t     ost_r, ost_nxt;
  logic [9:0]           onum_r, onum_nxt;
  logic                 onew_r, onew_nxt;
  logic [2:0]           ocls_r, ocls_nxt;
  logic                 oval_r, oval_nxt;
  ksa_pkg::side_stats_t ostat_r, ostat_nxt;

  logic                 accept, is_lf;
  logic [64:0]          prod;
  logic [31:0]          quo_mul, rem_full;
  logic [AW:0]          head_m1, nxt_m1;
  logic [AW+9:0]        idx_ext, e_ext;
  logic [KEYW-1:0]      cur_key;
  logic [2:0]           new_cls;
  ksa_pkg::side_stats_t upd;

  always_ff @(posedge clk) begin
    if (hwe) head_mem[hwa] <= hwd;
    head_rd_r <= head_mem[hra];
  end

  always_ff @(posedge clk) begin
    if (ewe) ent_mem[e_r] <= row_w;
    row_rd_r <= ent_mem[era];
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_lf    = (in_ch.data_byte == ksa_pkg::CH_LF);
  assign byte_we  = accept && !in_ch.req_type && !is_lf;
  assign cur_key  = {sym_buf, bin_buf};
  assign head_m1  = head_rd_r - 1'b1;
  assign nxt_m1   = row_rd_r.nxt - 1'b1;
  assign idx_ext  = {{AW{1'b0}}, in_ch.entry_index};
  assign e_ext    = {10'd0, e_r};
  assign prod     = mod_r * RECIP;
  assign quo_mul  = quo_r * 32'(HASH_BUCKETS);
  assign rem_full = mod_r - quo_mul;

  function automatic logic name_is(input logic [BIN_BYTES*8-1:0] buf_v,
                                   input logic [63:0] lit);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < BIN_BYTES; i++) begin
      if (buf_v[i*8 +: 8] != ((i < 8) ? lit[(i%8)*8 +: 8] : 8'd0)) eq = 1'b0;
    end
    return eq;
  endfunction

  function automatic logic sym_is(input logic [SYM_BYTES*8-1:0] buf_v,
                                  input logic [63:0] lit);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < SYM_BYTES; i++) begin
      if (buf_v[i*8 +: 8] != ((i < 8) ? lit[(i%8)*8 +: 8] : 8'd0)) eq = 1'b0;
    end
    return eq;
  endfunction

  always_comb begin
    if      (name_is(bin_buf, ksa_pkg::LIT_TOTAL))  new_cls = ksa_pkg::CLS_TOTAL;
    else if (name_is(bin_buf, ksa_pkg::LIT_IDLE))   new_cls = ksa_pkg::CLS_IDLE;
    else if (name_is(bin_buf, ksa_pkg::LIT_SYSTEM)) new_cls = ksa_pkg::CLS_SYSTEM;
    else if (name_is(bin_buf, ksa_pkg::LIT_USER))   new_cls = ksa_pkg::CLS_USER;
    else if (sym_is(sym_buf, ksa_pkg::LIT_TOTAL))   new_cls = ksa_pkg::CLS_PROC_TOTAL;
    else                                            new_cls = ksa_pkg::CLS_SYMBOL;
  end

  always_comb begin
    upd     = row_r.st[side_r];
    upd.sum = upd.sum + n_r;
    upd.sq  = upd.sq + sq_r;
    if (upd.mn > n_r) upd.mn = n_r;
    if (upd.mx < n_r) upd.mx = n_r;
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    used_nxt   = used_r;
    mod_nxt    = mod_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    e_nxt      = e_r;
    head_nxt   = head_r;
    side_nxt   = side_r;
    n_nxt      = n_r;
    sq_nxt     = sq_r;
    row_nxt    = row_r;
    fresh_nxt  = fresh_r;
    idx_nxt    = idx_r;
    idx_ok_nxt = idx_ok_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ost_nxt    = ost_r;
    onum_nxt   = onum_r;
    onew_nxt   = onew_r;
    ocls_nxt   = ocls_r;
    oval_nxt   = oval_r;
    ostat_nxt  = ostat_r;
    in_ch.ready = 1'b0;
    line_clr   = 1'b0;
    hwe        = 1'b0;
    hwa        = clr_r;
    hwd        = '0;
    hra        = rem_r;
    ewe        = 1'b0;
    era        = e_r;
    row_w      = row_r;

    case (state_r)
      ksa_pkg::TS_CLEAR: begin
        hwe     = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_BKT) state_nxt = ksa_pkg::TS_IDLE;
      end
      ksa_pkg::TS_IDLE: begin
        // a waiting result that leaves in this cycle frees the output register
        in_ch.ready = !ov_r || out_ch.ready;
        era         = idx_ext[AW-1:0];
        if (accept) begin
          side_nxt = in_ch.side;
          if (in_ch.req_type) begin
            idx_nxt    = in_ch.entry_index;
            idx_ok_nxt = ({{(AW+1){1'b0}}, in_ch.entry_index} < {10'd0, used_r});
            state_nxt  = ksa_pkg::TS_RRSP;
          end else if (is_lf) begin
            if (info.phase == ksa_pkg::PH_COUNT) begin
              n_nxt     = info.count;
              mod_nxt   = info.hash;
              state_nxt = ksa_pkg::TS_MOD;
            end else begin
              line_clr  = 1'b1;
              ov_nxt    = 1'b1;
              onum_nxt  = '0;
              onew_nxt  = 1'b0;
              ocls_nxt  = '0;
              oval_nxt  = 1'b0;
              ostat_nxt = '0;
              case (info.phase)
                ksa_pkg::PH_BINARY: ost_nxt = ksa_pkg::STS_BAD_BINARY;
                ksa_pkg::PH_SYMBOL: ost_nxt = ksa_pkg::STS_BAD_SYMBOL;
                default:            ost_nxt = ksa_pkg::STS_BAD_COUNT;
              endcase
            end
          end
        end
      end
      ksa_pkg::TS_MOD: begin
        // quotient by reciprocal multiplication
        quo_nxt   = 32'(prod >> QSH);
        state_nxt = ksa_pkg::TS_REM;
      end
      ksa_pkg::TS_REM: begin
        rem_nxt   = rem_full[BKW-1:0];
        state_nxt = ksa_pkg::TS_HEAD;
      end
      ksa_pkg::TS_HEAD: begin
        state_nxt = ksa_pkg::TS_HLINK;
      end
      ksa_pkg::TS_HLINK: begin
        head_nxt = head_rd_r;
        if (head_rd_r == '0) begin
          state_nxt = ksa_pkg::TS_NEW;
        end else begin
          era       = head_m1[AW-1:0];
          e_nxt     = head_m1[AW-1:0];
          state_nxt = ksa_pkg::TS_CMP;
        end
      end
      ksa_pkg::TS_CMP: begin
        if (row_rd_r.key == cur_key) begin
          row_nxt   = row_rd_r;
          fresh_nxt = 1'b0;
          state_nxt = ksa_pkg::TS_MUL;
        end else if (row_rd_r.nxt == '0) begin
          state_nxt = ksa_pkg::TS_NEW;
        end else begin
          era   = nxt_m1[AW-1:0];
          e_nxt = nxt_m1[AW-1:0];
        end
      end
      ksa_pkg::TS_NEW: begin
        if (used_r >= (AW+1)'(MAX_ENTRIES)) begin
          line_clr  = 1'b1;
          ov_nxt    = 1'b1;
          ost_nxt   = ksa_pkg::STS_FULL;
          onum_nxt  = '0;
          onew_nxt  = 1'b0;
          ocls_nxt  = '0;
          oval_nxt  = 1'b0;
          ostat_nxt = '0;
          state_nxt = ksa_pkg::TS_IDLE;
        end else begin
          hwe         = 1'b1;
          hwa         = rem_r;
          hwd         = used_r + 1'b1;
          e_nxt       = used_r[AW-1:0];
          used_nxt    = used_r + 1'b1;
          row_nxt.key = cur_key;
          row_nxt.cls = new_cls;
          row_nxt.nxt = head_r;
          row_nxt.st  = {ksa_pkg::STATS_FRESH, ksa_pkg::STATS_FRESH};
          fresh_nxt   = 1'b1;
          state_nxt   = ksa_pkg::TS_MUL;
        end
      end
      ksa_pkg::TS_MUL: begin
        sq_nxt    = {32'd0, n_r} * {32'd0, n_r};
        state_nxt = ksa_pkg::TS_TALLY;
      end
      ksa_pkg::TS_TALLY: begin
        row_w.st[side_r] = upd;
        ewe       = 1'b1;
        line_clr  = 1'b1;
        ov_nxt    = 1'b1;
        ost_nxt   = ksa_pkg::STS_TALLIED;
        onum_nxt  = e_ext[9:0];
        onew_nxt  = fresh_r;
        ocls_nxt  = row_r.cls;
        oval_nxt  = 1'b1;
        ostat_nxt = upd;
        state_nxt = ksa_pkg::TS_IDLE;
      end
      ksa_pkg::TS_RRSP: begin
        ov_nxt   = 1'b1;
        ost_nxt  = ksa_pkg::STS_READ;
        onum_nxt = idx_r;
        onew_nxt = 1'b0;
        if (idx_ok_r) begin
          ocls_nxt  = row_rd_r.cls;
          oval_nxt  = 1'b1;
          ostat_nxt = row_rd_r.st[side_r];
        end else begin
          ocls_nxt  = '0;
          oval_nxt  = 1'b0;
          ostat_nxt = '{sum: 32'd0, sq: 64'd0, mn: '1, mx: 32'd0};
        end
        state_nxt = ksa_pkg::TS_IDLE;
      end
      default: begin
        state_nxt = ksa_pkg::TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ksa_pkg::TS_CLEAR;
      clr_r   <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mod_r    <= mod_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    e_r      <= e_nxt;
    head_r   <= head_nxt;
    side_r   <= side_nxt;
    n_r      <= n_nxt;
    sq_r     <= sq_nxt;
    row_r    <= row_nxt;
    fresh_r  <= fresh_nxt;
    idx_r    <= idx_nxt;
    idx_ok_r <= idx_ok_nxt;
    ost_r    <= ost_nxt;
    onum_r   <= onum_nxt;
    onew_r   <= onew_nxt;
    ocls_r   <= ocls_nxt;
    oval_r   <= oval_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.status         = ost_r;
  assign out_ch.entry_number   = onum_r;
  assign out_ch.is_new         = onew_r;
  assign out_ch.entry_class    = ocls_r;
  assign out_ch.entry_valid    = oval_r;
  assign out_ch.total_sum      = ostat_r.sum;
  assign out_ch.square_sum     = ostat_r.sq;
  assign out_ch.least_count    = ostat_r.mn;
  assign out_ch.greatest_count = ostat_r.mx;

endmodule
